// ===== rtl/iad_pkg.sv =====
// iad_pkg: request/response payload types, cell command type and opcode/status codes
// for the indexed array insert/delete/search core. No dependencies.
package iad_pkg;

  localparam int VAL_W  = 32;
  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int FILL_W = 8;

  // match reduction: lowest hit inside a group of cells, then lowest group
  localparam int GROUP_SIZE = 16;
  localparam int GROUP_W    = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [POS_W-1:0]  found_position;
    logic [FILL_W-1:0] fill_count;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             cmp;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/iad_cell.sv =====
// iad_cell: one array slot; shifts with its neighbors and flags a search hit.
// Depends on iad_pkg.
module iad_cell #(
  parameter int IDX = 0,
  parameter int CW  = 8
) (
  input  logic                     clk,
  input  iad_pkg::cell_cmd_t       cmd,
  input  logic [CW-1:0]            count,
  input  logic [iad_pkg::VAL_W-1:0] left,
  input  logic [iad_pkg::VAL_W-1:0] right,
  output logic [iad_pkg::VAL_W-1:0] entry,
  output logic                     match
);

  localparam int IW = (CW > iad_pkg::POS_W) ? CW : iad_pkg::POS_W;

  logic [IW-1:0] idx_x;
  logic [IW-1:0] pos_x;
  logic [IW-1:0] cnt_x;

  assign idx_x = IW'(IDX);
  assign pos_x = IW'(cmd.pos);
  assign cnt_x = IW'(count);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (idx_x > pos_x) begin
        entry <= left;
      end else if (idx_x == pos_x) begin
        entry <= cmd.value;
      end
    end
    if (cmd.del && (idx_x >= pos_x)) begin
      entry <= right;
    end
    if (cmd.cmp) begin
      match <= (entry == cmd.value) && (idx_x < cnt_x);
    end
  end

endmodule

// ===== rtl/iad_lowest.sv =====
// iad_lowest: finds the lowest set bit of a small vector.
// Depends on nothing.
module iad_lowest #(
  parameter int N  = 16,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  bits,
  output logic          any,
  output logic [IW-1:0] idx
);

  always_comb begin
    any = |bits;
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

// ===== rtl/indexed_array_insert_delete_search_core.sv =====
// indexed_array_insert_delete_search_core: ordered array of signed 32-bit values
// built as a row of shifting cells. Depends on iad_pkg, iad_cell, iad_lowest.
//
//  channel | valid     | stall     | payload          | direction
//  --------+-----------+-----------+------------------+----------
//  request | req_valid | req_stall | req (req_t)      | in
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)      | out
//
// On insert and delete every cell loads from its left or right
// neighbor in the accept cycle and the result is registered at the same edge.
// On search, cells register their hit flags, a registered stage finds the lowest
// hit in each group of 16 cells, then the lowest group is chosen.
// One request is in flight at a time; a new request is taken while the previous
// result is being handed off. rst clears the fill count, the sequencer and
// rsp_valid; cell contents are not cleared and only slots below the count are read.
// rsp_stall holds the result register and with it the request side.
module indexed_array_insert_delete_search_core #(
  parameter int DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  iad_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output iad_pkg::rsp_t rsp
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (CW > iad_pkg::POS_W) ? CW : iad_pkg::POS_W;
  localparam int GS   = iad_pkg::GROUP_SIZE;
  localparam int GSW  = iad_pkg::GROUP_W;
  localparam int NG   = (DEPTH + GS - 1) / GS;
  localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int NGP  = 1 << GIW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GROUP,
    S_FINAL
  } state_t;

  state_t state;
  state_t state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic accept;
  logic is_ins;
  logic is_del;
  logic is_srch;
  logic full;
  logic ins_ok;
  logic del_ok;
  logic [IW-1:0] pos_x;
  logic [IW-1:0] cnt_x;

  iad_pkg::cell_cmd_t cmd;
  iad_pkg::rsp_t      rsp_next;
  logic               rsp_load;

  logic [iad_pkg::VAL_W-1:0] ent [DEPTH];
  logic [NGP*GS-1:0]         match_all;

  logic           g_any_c [NGP];
  logic [GSW-1:0] g_idx_c [NGP];
  logic [NGP-1:0] grp_any;
  logic [GSW-1:0] grp_idx [NGP];

  logic           sel_any;
  logic [GIW-1:0] sel_g;
  logic [GIW+GSW-1:0] hit_pos;

  // ------------------------------------------------------------------
  // request decode and bounds checks
  // ------------------------------------------------------------------
  assign req_stall = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign accept    = req_valid && !req_stall;

  assign is_ins  = (req.opcode == iad_pkg::OP_INSERT);
  assign is_del  = (req.opcode == iad_pkg::OP_DELETE);
  assign is_srch = (req.opcode == iad_pkg::OP_SEARCH);

  assign pos_x  = IW'(req.position);
  assign cnt_x  = IW'(count);
  assign full   = (cnt_x >= IW'(DEPTH));
  // full check wins over the position check; append at pos == count is legal
  assign ins_ok = !full && (pos_x <= cnt_x);
  assign del_ok = (pos_x < cnt_x);

  assign cmd.ins   = accept && is_ins && ins_ok;
  assign cmd.del   = accept && is_del && del_ok;
  assign cmd.cmp   = accept && is_srch;
  assign cmd.pos   = req.position;
  assign cmd.value = req.value;

  // ------------------------------------------------------------------
  // row of cells; each loads from a neighbor on a shift
  // ------------------------------------------------------------------
  for (genvar k = 0; k < NGP * GS; k++) begin : g_row
    if (k < DEPTH) begin : g_cell
      logic [iad_pkg::VAL_W-1:0] left_d;
      logic [iad_pkg::VAL_W-1:0] right_d;

      if (k == 0) begin : g_first
        assign left_d = req.value;
      end else begin : g_mid_l
        assign left_d = ent[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
        assign right_d = ent[k];
      end else begin : g_mid_r
        assign right_d = ent[k+1];
      end

      iad_cell #(
        .IDX (k),
        .CW  (CW)
      ) u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .count (count),
        .left  (left_d),
        .right (right_d),
        .entry (ent[k]),
        .match (match_all[k])
      );
    end else begin : g_pad
      assign match_all[k] = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // search reduction: lowest hit per group, registered, then lowest group
  // ------------------------------------------------------------------
  for (genvar g = 0; g < NGP; g++) begin : g_grp
    iad_lowest #(
      .N (GS)
    ) u_grp (
      .bits (match_all[g*GS +: GS]),
      .any  (g_any_c[g]),
      .idx  (g_idx_c[g])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_GROUP) begin
      for (int g = 0; g < NGP; g++) begin
        grp_any[g] <= g_any_c[g];
        grp_idx[g] <= g_idx_c[g];
      end
    end
  end

  iad_lowest #(
    .N (NGP)
  ) u_top (
    .bits (grp_any),
    .any  (sel_any),
    .idx  (sel_g)
  );

  assign hit_pos = {sel_g, grp_idx[sel_g]};

  // ------------------------------------------------------------------
  // sequencer and result register
  // ------------------------------------------------------------------
  always_comb begin
    state_next = state;
    count_next = count;
    rsp_load   = 1'b0;
    rsp_next   = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.ins) begin
            count_next = count + 1'b1;
          end else if (cmd.del) begin
            count_next = count - 1'b1;
          end
          if (is_srch) begin
            state_next = S_GROUP;
          end else begin
            rsp_load = 1'b1;
            if (is_ins) begin
              if (full) begin
                rsp_next.status = iad_pkg::ST_FULL;
              end else if (!ins_ok) begin
                rsp_next.status = iad_pkg::ST_RANGE;
              end
            end else if (is_del && !del_ok) begin
              rsp_next.status = iad_pkg::ST_RANGE;
            end
            rsp_next.fill_count = iad_pkg::FILL_W'(count_next);
          end
        end
      end
      S_GROUP: begin
        state_next = S_FINAL;
      end
      S_FINAL: begin
        state_next              = S_IDLE;
        rsp_load                = 1'b1;
        rsp_next.status         = iad_pkg::ST_OK;
        rsp_next.found          = sel_any;
        rsp_next.found_position = sel_any ? iad_pkg::POS_W'(hit_pos) : '0;
        rsp_next.fill_count     = iad_pkg::FILL_W'(count);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (IW'(count) <= IW'(DEPTH)))
    else $error("fill count above depth");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found) |-> (rsp.status == iad_pkg::ST_OK))
    else $error("search hit with non-ok status");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("request taken during search");

  a_quick_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req.opcode != iad_pkg::OP_SEARCH)) |=> rsp_valid)
    else $error("no result after insert or delete");

endmodule
